// File: rtl/bth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// Shared constants and types for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam int BTH_HEAP_WORDS = 1024;
    localparam logic [13:0] BTH_MAX_UNUSED_RESET = 14'd64;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;
    localparam logic [1:0] MODE_BEST  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    localparam logic CFG_SEARCH_MODE = 1'b0;
    localparam logic CFG_MAX_UNUSED  = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT_HEAD,
        ST_INIT_FOOT,
        ST_IDLE,
        ST_WALK,
        ST_NEXT_TAG,
        ST_DECIDE,
        ST_WR_HEAD,
        ST_WR_FOOT,
        ST_WR_RHEAD,
        ST_WR_RFOOT,
        ST_DONE
    } bth_state_t;

endpackage

// File: rtl/bth_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bth_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/boundary_tag_heap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_unit
// Implicit free-list heap allocator with boundary tags held in one tag RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. An allocate walks the block headers from word 0,
// one tag RAM read per cycle (the RAM output feeds the next read address), so
// it walks through every block and then enters ST_DECIDE. When nothing fits
// it goes to ST_DONE; a grant first writes the head and foot tags, and
// with a split also the remainder's head and foot tags. A free walks up to the
// freed block and, if it is in use, takes the next tag and writes the merged
// head and foot tags. The worst case is set by the walk: 2-word blocks in use
// alternating with 1-word free leftovers give about 2 * HEAP_WORDS / 3 blocks.
// After reset the block writes the initial free-block tags before it accepts.
module boundary_tag_heap_allocator_unit
    import bth_pkg::*;
#(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[13:0], release_offset[26:14]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // payload_offset[12:0], granted_bytes[26:13]
    output logic        m_tuser,   // status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_wdata
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = $clog2(HEAP_WORDS + 1);
    localparam int TW = SW + 1;
    localparam int PW = (SW > 10) ? SW : 10;
    localparam int CW = ((SW + 3) > 16 ? (SW + 3) : 16) + 1;
    localparam logic [PW:0] HEAP_END = (PW + 1)'(HEAP_WORDS);

    bth_state_t state_reg, state_next;

    logic [1:0]    mode_reg, mode_next;
    logic [13:0]   max_unused_reg, max_unused_next;
    logic [AW-1:0] rover_reg, rover_next;
    logic          act_reg, act_next;
    logic [11:0]   need_reg, need_next;
    logic [PW-1:0] target_reg, target_next;
    logic [PW-1:0] b_reg, b_next;

    logic          first_ok_reg, first_ok_next, next_ok_reg, next_ok_next;
    logic          best_ok_reg, best_ok_next;
    logic [AW-1:0] first_b_reg, first_b_next, next_b_reg, next_b_next;
    logic [AW-1:0] best_b_reg, best_b_next;
    logic [SW-1:0] first_sz_reg, first_sz_next, next_sz_reg, next_sz_next;
    logic [SW-1:0] best_sz_reg, best_sz_next;

    logic          prev_ok_reg, prev_ok_next, prev_used_reg, prev_used_next;
    logic [AW-1:0] prev_b_reg, prev_b_next;
    logic [SW-1:0] prev_sz_reg, prev_sz_next;
    logic [SW-1:0] tsize_reg, tsize_next;
    logic [PW:0]   nxt_reg, nxt_next;

    logic [AW-1:0] blk_start_reg, blk_start_next, rem_start_reg, rem_start_next;
    logic [SW-1:0] blk_words_reg, blk_words_next, rem_words_reg, rem_words_next;
    logic          blk_used_reg, blk_used_next, split_reg, split_next;

    logic          rs_status_reg, rs_status_next;
    logic [12:0]   rs_off_reg, rs_off_next;
    logic [13:0]   rs_gb_reg, rs_gb_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_status_reg, m_status_next;
    logic [12:0]   m_off_reg, m_off_next;
    logic [13:0]   m_gb_reg, m_gb_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [TW-1:0] ram_wdata, ram_rdata;

    logic [SW-1:0] rd_sz;
    logic          rd_used;
    logic [PW:0]   nb_wide;
    logic          rd_bad, walk_last, fit, out_free;
    logic [12:0]   in_off;
    logic [13:0]   in_req;
    logic [PW-1:0] in_target;
    logic          in_off_ok;

    bth_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_tags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_sz     = ram_rdata[TW-1:1];
    assign rd_used   = ram_rdata[0];
    assign nb_wide   = (PW + 1)'(b_reg) + (PW + 1)'(rd_sz);
    assign rd_bad    = (rd_sz == '0) || (nb_wide > HEAP_END);
    assign walk_last = rd_bad || (nb_wide == HEAP_END);
    assign fit       = !rd_used && ((CW)'(rd_sz) >= (CW)'(need_reg));
    assign out_free  = !m_tvalid_reg || m_tready;

    assign in_req    = s_tdata[13:0];
    assign in_off    = s_tdata[26:14];
    assign in_target = (PW)'(in_off[12:3]) - (PW)'(1);
    assign in_off_ok = (in_off[2:0] == 3'd0) && (in_off[12:3] != 10'd0) &&
                       ((PW + 1)'(in_target) < HEAP_END);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT_HEAD: state_next = ST_INIT_FOOT;
            ST_INIT_FOOT: state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == ACT_ALLOC || in_off_ok) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (act_reg == ACT_ALLOC) begin
                    if (walk_last) begin
                        state_next = ST_DECIDE;
                    end
                end else if (rd_bad || b_reg > target_reg) begin
                    state_next = ST_DONE;
                end else if (b_reg == target_reg) begin
                    state_next = rd_used ? ST_NEXT_TAG : ST_DONE;
                end else if (walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_NEXT_TAG: state_next = ST_WR_HEAD;
            ST_DECIDE: begin
                if ((mode_reg == MODE_BEST) ? best_ok_reg : (first_ok_reg || next_ok_reg)) begin
                    state_next = ST_WR_HEAD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WR_HEAD:  state_next = ST_WR_FOOT;
            ST_WR_FOOT:  state_next = split_reg ? ST_WR_RHEAD : ST_DONE;
            ST_WR_RHEAD: state_next = ST_WR_RFOOT;
            ST_WR_RFOOT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        s_tready  = 1'b0;
        case (state_reg)
            ST_INIT_HEAD: begin
                ram_we    = 1'b1;
                ram_wdata = {(SW)'(HEAP_WORDS), 1'b0};
            end
            ST_INIT_FOOT: begin
                ram_we    = 1'b1;
                ram_waddr = (AW)'(HEAP_WORDS - 1);
                ram_wdata = {(SW)'(HEAP_WORDS), 1'b0};
            end
            ST_IDLE: s_tready = 1'b1;
            ST_WALK: ram_raddr = nb_wide[AW-1:0];
            ST_WR_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = blk_start_reg;
                ram_wdata = {blk_words_reg, blk_used_reg};
            end
            ST_WR_FOOT: begin
                ram_we    = 1'b1;
                ram_waddr = (AW)'(blk_start_reg + blk_words_reg - 1'b1);
                ram_wdata = {blk_words_reg, blk_used_reg};
            end
            ST_WR_RHEAD: begin
                ram_we    = 1'b1;
                ram_waddr = rem_start_reg;
                ram_wdata = {rem_words_reg, 1'b0};
            end
            ST_WR_RFOOT: begin
                ram_we    = 1'b1;
                ram_waddr = (AW)'(rem_start_reg + rem_words_reg - 1'b1);
                ram_wdata = {rem_words_reg, 1'b0};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_gb_reg, m_off_reg};

    // datapath
    always_comb begin
        logic          c_ok;
        logic [AW-1:0] c_b;
        logic [SW-1:0] c_sz;
        logic          c_split;
        logic          merged;
        logic [SW-1:0] fsize;
        logic [SW-1:0] gwords;
        logic [CW-1:0] offw, gbw;

        mode_next       = mode_reg;
        max_unused_next = max_unused_reg;
        rover_next      = rover_reg;
        act_next        = act_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        b_next          = b_reg;
        first_ok_next   = first_ok_reg;
        first_b_next    = first_b_reg;
        first_sz_next   = first_sz_reg;
        next_ok_next    = next_ok_reg;
        next_b_next     = next_b_reg;
        next_sz_next    = next_sz_reg;
        best_ok_next    = best_ok_reg;
        best_b_next     = best_b_reg;
        best_sz_next    = best_sz_reg;
        prev_ok_next    = prev_ok_reg;
        prev_used_next  = prev_used_reg;
        prev_b_next     = prev_b_reg;
        prev_sz_next    = prev_sz_reg;
        tsize_next      = tsize_reg;
        nxt_next        = nxt_reg;
        blk_start_next  = blk_start_reg;
        blk_words_next  = blk_words_reg;
        blk_used_next   = blk_used_reg;
        rem_start_next  = rem_start_reg;
        rem_words_next  = rem_words_reg;
        split_next      = split_reg;
        rs_status_next  = rs_status_reg;
        rs_off_next     = rs_off_reg;
        rs_gb_next      = rs_gb_reg;
        m_status_next   = m_status_reg;
        m_off_next      = m_off_reg;
        m_gb_next       = m_gb_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;

        if (mode_reg == MODE_BEST) begin
            c_ok = best_ok_reg;
            c_b  = best_b_reg;
            c_sz = best_sz_reg;
        end else if (mode_reg == MODE_NEXT && next_ok_reg) begin
            c_ok = 1'b1;
            c_b  = next_b_reg;
            c_sz = next_sz_reg;
        end else begin
            c_ok = first_ok_reg;
            c_b  = first_b_reg;
            c_sz = first_sz_reg;
        end
        c_split = ((CW)'(c_sz) > ((CW)'(need_reg) << 1)) ||
                  (((CW)'(c_sz) << 3) > (((CW)'(need_reg) << 3) + (CW)'(max_unused_reg)));
        gwords  = c_split ? (SW)'(need_reg) : c_sz;
        offw    = ((CW)'(c_b) + (CW)'(1)) << 3;
        gbw     = (CW)'(gwords) << 3;

        merged = (nxt_reg < HEAP_END) && !rd_used && (rd_sz != '0) &&
                 ((nxt_reg + (PW + 1)'(rd_sz)) <= HEAP_END);
        fsize  = tsize_reg + (merged ? rd_sz : '0) +
                 ((prev_ok_reg && !prev_used_reg) ? prev_sz_reg : '0);

        if (cfg_we) begin
            if (cfg_index == CFG_SEARCH_MODE) begin
                mode_next = cfg_wdata[1:0];
            end else begin
                max_unused_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                act_next       = s_tuser;
                need_next      = 12'((15'(in_req) + 15'd23) >> 3);
                target_next    = in_target;
                b_next         = '0;
                first_ok_next  = 1'b0;
                next_ok_next   = 1'b0;
                best_ok_next   = 1'b0;
                prev_ok_next   = 1'b0;
                split_next     = 1'b0;
                rs_status_next = STATUS_DONE;
                rs_off_next    = '0;
                rs_gb_next     = '0;
            end
            ST_WALK: begin
                b_next = nb_wide[PW-1:0];
                if (!rd_bad) begin
                    if (fit && !first_ok_reg) begin
                        first_ok_next = 1'b1;
                        first_b_next  = b_reg[AW-1:0];
                        first_sz_next = rd_sz;
                    end
                    if (fit && !next_ok_reg && b_reg >= (PW)'(rover_reg)) begin
                        next_ok_next = 1'b1;
                        next_b_next  = b_reg[AW-1:0];
                        next_sz_next = rd_sz;
                    end
                    if (fit && (!best_ok_reg || rd_sz < best_sz_reg)) begin
                        best_ok_next = 1'b1;
                        best_b_next  = b_reg[AW-1:0];
                        best_sz_next = rd_sz;
                    end
                    if (b_reg != target_reg) begin
                        prev_ok_next   = 1'b1;
                        prev_used_next = rd_used;
                        prev_b_next    = b_reg[AW-1:0];
                        prev_sz_next   = rd_sz;
                    end
                end
                tsize_next = rd_sz;
                nxt_next   = nb_wide;
            end
            ST_NEXT_TAG: begin
                blk_used_next  = 1'b0;
                blk_words_next = fsize;
                blk_start_next = (prev_ok_reg && !prev_used_reg) ? prev_b_reg
                                                                 : target_reg[AW-1:0];
                if ((PW)'(rover_reg) == target_reg ||
                    (merged && (PW + 1)'(rover_reg) == nxt_reg)) begin
                    rover_next = (prev_ok_reg && !prev_used_reg) ? prev_b_reg
                                                                 : target_reg[AW-1:0];
                end
            end
            ST_DECIDE: begin
                if (!c_ok) begin
                    rs_status_next = STATUS_NOFIT;
                end else begin
                    if (mode_reg != MODE_BEST) begin
                        rover_next = c_b;
                    end
                    blk_start_next = c_b;
                    blk_words_next = gwords;
                    blk_used_next  = 1'b1;
                    split_next     = c_split;
                    rem_start_next = (AW)'(c_b + need_reg);
                    rem_words_next = (SW)'(c_sz - need_reg);
                    rs_off_next    = offw[12:0];
                    rs_gb_next     = gbw[13:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = rs_status_reg;
                    m_off_next    = rs_off_reg;
                    m_gb_next     = rs_gb_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT_HEAD;
            mode_reg       <= MODE_FIRST;
            max_unused_reg <= BTH_MAX_UNUSED_RESET;
            rover_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            max_unused_reg <= max_unused_next;
            rover_reg      <= rover_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        need_reg      <= need_next;
        target_reg    <= target_next;
        b_reg         <= b_next;
        first_ok_reg  <= first_ok_next;
        first_b_reg   <= first_b_next;
        first_sz_reg  <= first_sz_next;
        next_ok_reg   <= next_ok_next;
        next_b_reg    <= next_b_next;
        next_sz_reg   <= next_sz_next;
        best_ok_reg   <= best_ok_next;
        best_b_reg    <= best_b_next;
        best_sz_reg   <= best_sz_next;
        prev_ok_reg   <= prev_ok_next;
        prev_used_reg <= prev_used_next;
        prev_b_reg    <= prev_b_next;
        prev_sz_reg   <= prev_sz_next;
        tsize_reg     <= tsize_next;
        nxt_reg       <= nxt_next;
        blk_start_reg <= blk_start_next;
        blk_words_reg <= blk_words_next;
        blk_used_reg  <= blk_used_next;
        rem_start_reg <= rem_start_next;
        rem_words_reg <= rem_words_next;
        split_reg     <= split_next;
        rs_status_reg <= rs_status_next;
        rs_off_reg    <= rs_off_next;
        rs_gb_reg     <= rs_gb_next;
        m_status_reg  <= m_status_next;
        m_off_reg     <= m_off_next;
        m_gb_reg      <= m_gb_next;
    end

    a_walk_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> (PW + 1)'(b_reg) < HEAP_END)
        else $error("walk pointer beyond heap");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_INIT_HEAD || state_reg == ST_INIT_FOOT ||
                    state_reg == ST_WR_HEAD || state_reg == ST_WR_FOOT ||
                    state_reg == ST_WR_RHEAD || state_reg == ST_WR_RFOOT))
        else $error("tag write outside write states");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not presented");

endmodule
